// ===== rtl/ccrc_pkg.sv =====
// Package: shared types and constants for the configurable CRC16/CRC32 core.
package ccrc_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned IndexWidth = 3;

   localparam logic [IndexWidth-1:0] RegWidthMode  = 3'd0;
   localparam logic [IndexWidth-1:0] RegReflected  = 3'd1;
   localparam logic [IndexWidth-1:0] RegPolynomial = 3'd2;
   localparam logic [IndexWidth-1:0] RegPreset     = 3'd3;
   localparam logic [IndexWidth-1:0] RegOutputMask = 3'd4;

   localparam logic [DataWidth-1:0] Mask32 = 32'hFFFF_FFFF;
   localparam logic [DataWidth-1:0] Mask16 = 32'h0000_FFFF;
   localparam logic [DataWidth-1:0] Top32  = 32'h8000_0000;
   localparam logic [DataWidth-1:0] Top16  = 32'h0000_8000;

   localparam logic [DataWidth-1:0] ResetPolynomial = 32'hEDB8_8320;
   localparam logic [DataWidth-1:0] ResetPreset     = 32'hFFFF_FFFF;
   localparam logic [DataWidth-1:0] ResetOutputMask = 32'hFFFF_FFFF;

   typedef struct packed {
      logic                 width_mode;
      logic                 reflected;
      logic [DataWidth-1:0] polynomial;
      logic [DataWidth-1:0] preset_value;
      logic [DataWidth-1:0] output_mask;
   } cfg_type;

endpackage

// ===== rtl/ccrc_csr.sv =====
// Configuration registers of the CRC core.
module ccrc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [ccrc_pkg::IndexWidth-1:0]     csr_index,
   input  logic [ccrc_pkg::DataWidth-1:0]      csr_write_data,
   output ccrc_pkg::cfg_type                   cfg
);

   ccrc_pkg::cfg_type cfg_ff;
   ccrc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ccrc_pkg::RegWidthMode:  cfg_in.width_mode   = csr_write_data[0];
            ccrc_pkg::RegReflected:  cfg_in.reflected    = csr_write_data[0];
            ccrc_pkg::RegPolynomial: cfg_in.polynomial   = csr_write_data;
            ccrc_pkg::RegPreset:     cfg_in.preset_value = csr_write_data;
            ccrc_pkg::RegOutputMask: cfg_in.output_mask  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_mode   <= 1'b1;
         cfg_ff.reflected    <= 1'b1;
         cfg_ff.polynomial   <= ccrc_pkg::ResetPolynomial;
         cfg_ff.preset_value <= ccrc_pkg::ResetPreset;
         cfg_ff.output_mask  <= ccrc_pkg::ResetOutputMask;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/ccrc_fold.sv =====
// Byte fold: preset load, eight shift-and-XOR steps and output XOR.
module ccrc_fold (
   input  ccrc_pkg::cfg_type                cfg,
   input  logic [ccrc_pkg::DataWidth-1:0]   crc_cur,
   input  logic [ccrc_pkg::ByteWidth-1:0]   data_byte,
   input  logic                             first,
   output logic [ccrc_pkg::DataWidth-1:0]   crc_next,
   output logic [ccrc_pkg::DataWidth-1:0]   crc_result
);

   logic [ccrc_pkg::DataWidth-1:0] mask;
   logic [ccrc_pkg::DataWidth-1:0] top;
   logic [ccrc_pkg::DataWidth-1:0] poly;
   logic [ccrc_pkg::DataWidth-1:0] start;
   logic [ccrc_pkg::DataWidth-1:0] byte_msb;
   logic [ccrc_pkg::DataWidth-1:0] r;

   assign mask     = cfg.width_mode ? ccrc_pkg::Mask32 : ccrc_pkg::Mask16;
   assign top      = cfg.width_mode ? ccrc_pkg::Top32 : ccrc_pkg::Top16;
   assign poly     = cfg.polynomial & mask;
   assign byte_msb = cfg.width_mode ? {data_byte, 24'h0} : {16'h0, data_byte, 8'h0};

   always_comb begin
      if (first) begin
         start = cfg.reflected ? cfg.preset_value : ~cfg.preset_value;
      end else begin
         start = crc_cur;
      end
      r = start & mask;
      if (cfg.reflected) begin
         r = r ^ {24'h0, data_byte};
         for (int k = 0; k < ccrc_pkg::ByteWidth; k++) begin
            r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
         end
      end else begin
         r = r ^ byte_msb;
         for (int k = 0; k < ccrc_pkg::ByteWidth; k++) begin
            r = ((r << 1) & mask) ^ ((|(r & top)) ? poly : '0);
         end
      end
   end

   assign crc_next   = r & mask;
   assign crc_result = (r ^ cfg.output_mask) & mask;

endmodule

// ===== rtl/configurable_crc16_crc32_core.sv =====
// Top level of the configurable CRC16/CRC32 core.
//
//  port group | dir | handshake          | payload
//  req_       | in  | req_valid/ready    | data_byte[7:0], first, last
//  rsp_       | out | rsp_valid/ready    | crc_value[31:0]
//  csr_       | in  | csr_write_enable   | index[2:0], write_data[31:0]
//
// One byte per cycle sustained unless a last byte waits. A byte is folded
// from the input register; a last byte's CRC goes into the result register.
// The running CRC register loops through the fold of one byte, 8 steps.
// Synchronous reset clears control state and restores configuration defaults.
// A last byte waits in the input register while a result is held by rsp_ready.
module configurable_crc16_crc32_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ccrc_pkg::ByteWidth-1:0]      req_data_byte,
   input  logic                                req_first,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ccrc_pkg::DataWidth-1:0]      rsp_crc_value,
   input  logic                                csr_write_enable,
   input  logic [ccrc_pkg::IndexWidth-1:0]     csr_index,
   input  logic [ccrc_pkg::DataWidth-1:0]      csr_write_data
);

   ccrc_pkg::cfg_type cfg;

   logic                              s1_valid_ff;
   logic                              s1_valid_in;
   logic [ccrc_pkg::ByteWidth-1:0]    s1_byte_ff;
   logic                              s1_first_ff;
   logic                              s1_last_ff;
   logic [ccrc_pkg::DataWidth-1:0]    crc_ff;
   logic [ccrc_pkg::DataWidth-1:0]    crc_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [ccrc_pkg::DataWidth-1:0]    rsp_crc_ff;
   logic [ccrc_pkg::DataWidth-1:0]    crc_result;
   logic                              out_free;
   logic                              s1_fire;
   logic                              req_take;

   ccrc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ccrc_fold u_fold (
      .cfg        (cfg),
      .crc_cur    (crc_ff),
      .data_byte  (s1_byte_ff),
      .first      (s1_first_ff),
      .crc_next   (crc_in),
      .crc_result (crc_result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = (s1_fire && s1_last_ff) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_data_byte;
         s1_first_ff <= req_first;
         s1_last_ff  <= req_last;
      end
      if (s1_fire && s1_last_ff) begin
         rsp_crc_ff <= crc_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

endmodule

// ===== rtl/ccrc_checker.sv =====
// Port-level checker for the CRC core, bound to the top level.
module ccrc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_last,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [ccrc_pkg::DataWidth-1:0]      rsp_crc_value
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crc_value))
      else $error("stalled result changed or dropped");

   a_stall_only_on_full_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without a stalled result");

   a_no_result_from_middle_byte: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last |=> ##1 !$rose(rsp_valid))
      else $error("result appeared for a byte without last");

endmodule

bind configurable_crc16_crc32_core ccrc_checker u_ccrc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_crc_value (rsp_crc_value)
);
